FILE: rtl/core/mlcd_pkg.sv
// Package with shared types and constants for the mouse-look camera direction block.
`timescale 1ns / 1ps

package mlcd_pkg;

    localparam int TableSize = 24;

    localparam logic signed [18:0] FullTurn    = 19'sd92160;
    localparam logic signed [18:0] HalfTurn    = 19'sd46080;
    localparam logic signed [18:0] QuarterTurn = 19'sd23040;
    localparam logic signed [18:0] PitchLimit  = 19'sd22784;
    localparam logic [11:0]        SensReset   = 12'd128;
    localparam logic signed [31:0] CordicGain  = 32'sd163008219;
    localparam logic signed [15:0] OneQ14      = 16'sd16384;

    typedef logic signed [31:0] t_cval;
    typedef logic signed [25:0] t_zval;

    // Arctangent of 2^-i in degrees Q.16.
    function automatic t_zval f_atan(input logic [4:0] idx);
        t_zval v;
        begin
            v = '0;
            case (idx)
                5'd0:  v = 26'sd2949120;
                5'd1:  v = 26'sd1740967;
                5'd2:  v = 26'sd919879;
                5'd3:  v = 26'sd466945;
                5'd4:  v = 26'sd234379;
                5'd5:  v = 26'sd117304;
                5'd6:  v = 26'sd58666;
                5'd7:  v = 26'sd29335;
                5'd8:  v = 26'sd14668;
                5'd9:  v = 26'sd7334;
                5'd10: v = 26'sd3667;
                5'd11: v = 26'sd1833;
                5'd12: v = 26'sd917;
                5'd13: v = 26'sd458;
                5'd14: v = 26'sd229;
                5'd15: v = 26'sd115;
                5'd16: v = 26'sd57;
                5'd17: v = 26'sd29;
                5'd18: v = 26'sd14;
                5'd19: v = 26'sd7;
                5'd20: v = 26'sd4;
                5'd21: v = 26'sd2;
                5'd22: v = 26'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Round a Q2.28 value to Q1.14 and clamp to plus or minus one.
    function automatic logic signed [15:0] f_round14(input logic signed [32:0] v);
        logic signed [32:0] r;
        begin
            r = (v + 33'sd8192) >>> 14;
            if (r > 33'sd16384) begin
                return OneQ14;
            end else if (r < -33'sd16384) begin
                return -OneQ14;
            end
            return r[15:0];
        end
    endfunction

endpackage

FILE: rtl/core/mlcd_cordic.sv
// Iterative CORDIC rotation giving cosine and sine of an angle in degrees Q.8.
`timescale 1ns / 1ps

module mlcd_cordic
    import mlcd_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [18:0] i_angle,
    output logic               o_done,
    output logic signed [15:0] o_cos,
    output logic signed [15:0] o_sin
);

    localparam int Steps = (CORDIC_STEPS > TableSize) ? TableSize : CORDIC_STEPS;

    logic         r_busy;
    logic [4:0]   r_idx;
    logic         r_neg;
    t_cval        r_x;
    t_cval        r_y;
    t_zval        r_z;
    logic         r_done;
    logic signed [15:0] r_cos;
    logic signed [15:0] r_sin;

    logic signed [18:0] fold;
    logic         fold_neg;
    t_cval        xs;
    t_cval        ys;
    t_cval        n_x;
    t_cval        n_y;
    t_zval        n_z;
    logic signed [15:0] c_r;
    logic signed [15:0] s_r;

    always_comb begin
        fold     = i_angle;
        fold_neg = 1'b0;
        if (i_angle > QuarterTurn) begin
            fold     = i_angle - HalfTurn;
            fold_neg = 1'b1;
        end else if (i_angle < -QuarterTurn) begin
            fold     = i_angle + HalfTurn;
            fold_neg = 1'b1;
        end
        xs = r_x >>> r_idx;
        ys = r_y >>> r_idx;
        if (!r_z[25]) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - f_atan(r_idx);
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + f_atan(r_idx);
        end
        c_r = f_round14({r_x[31], r_x});
        s_r = f_round14({r_y[31], r_y});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_neg  <= fold_neg;
                r_x    <= CordicGain;
                r_y    <= '0;
                r_z    <= {fold[17:0], 8'd0};
            end else if (r_busy) begin
                if (r_idx == 5'(Steps)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_cos  <= r_neg ? -c_r : c_r;
                    r_sin  <= r_neg ? -s_r : s_r;
                end else begin
                    r_x   <= n_x;
                    r_y   <= n_y;
                    r_z   <= n_z;
                    r_idx <= r_idx + 5'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

FILE: rtl/core/mouse_look_camera_direction.sv
// Top level of the mouse-look camera direction block.
`timescale 1ns / 1ps
// Usage:
//   Cursor position items enter on i_cursor_valid / o_cursor_ready with
//   i_cursor_x and i_cursor_y. Each item yields one direction item on
//   o_dir_valid / i_dir_ready carrying the unit look vector (Q1.14) and the
//   updated yaw and pitch angles (degrees Q.8).
//   The sensitivity register is written through i_cfg_valid / o_cfg_ready.
//   After acceptance, S_MULX and S_MULY scale the deltas and S_ACC
//   accumulates them, two passes go through the shared CORDIC unit (yaw
//   first, then pitch), S_PRX and S_PRZ form the two cos(pitch) products on
//   the shared multiplier, and S_OUT loads the output register.
//   o_cursor_ready is high while no item is in work, so a new item is taken
//   only once the last one has moved on to the output register.
//   The first item after reset only seeds the previous cursor position, so
//   its result shows the unchanged zero yaw and pitch.
//   Reset clears yaw, pitch and the previous position and restores the
//   sensitivity to 0.5 degree per pixel.
//   When the receiver stalls the result holds in the output register; one
//   more item can be accepted and worked, and it then waits until the output
//   register is free, so no further item is accepted meanwhile.

module mouse_look_camera_direction
    import mlcd_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [11:0]        i_look_sensitivity,
    input  logic               i_cursor_valid,
    output logic               o_cursor_ready,
    input  logic signed [15:0] i_cursor_x,
    input  logic signed [15:0] i_cursor_y,
    output logic               o_dir_valid,
    input  logic               i_dir_ready,
    output logic signed [15:0] o_dir_x,
    output logic signed [15:0] o_dir_y,
    output logic signed [15:0] o_dir_z,
    output logic [16:0]        o_yaw_angle,
    output logic signed [15:0] o_pitch_angle
);

    typedef enum logic [3:0] {
        S_IDLE, S_MULX, S_MULY, S_ACC, S_YAW, S_YAWW, S_PIT, S_PITW, S_PRX, S_PRZ, S_OUT
    } t_state;

    t_state r_state;
    logic [11:0] r_sens;
    logic signed [15:0] r_prev_x;
    logic signed [15:0] r_prev_y;
    logic [16:0] r_yaw;
    logic signed [15:0] r_pitch;
    logic r_first;
    logic signed [16:0] r_dx;
    logic signed [16:0] r_dy;
    logic signed [18:0] r_sdx;
    logic signed [18:0] r_sdy;
    logic signed [15:0] r_cy;
    logic signed [15:0] r_sy;
    logic signed [15:0] r_cp;
    logic signed [15:0] r_sp;
    logic r_valid;
    logic signed [15:0] r_ox;
    logic signed [15:0] r_oz;

    // Output register, kept apart from the working state.
    logic signed [15:0] r_dir_x;
    logic signed [15:0] r_dir_y;
    logic signed [15:0] r_dir_z;
    logic [16:0]        r_dir_yaw;
    logic signed [15:0] r_dir_pitch;

    // Shared multiplier operands.
    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] mul_p;
    logic signed [18:0] sat_p;
    logic signed [15:0] q14_p;

    logic               cs_start;
    logic signed [18:0] cs_angle;
    logic               cs_done;
    logic signed [15:0] cs_cos;
    logic signed [15:0] cs_sin;

    logic signed [19:0] yaw_sum;
    logic signed [19:0] yaw_wrap;
    logic signed [19:0] pit_sum;
    logic signed [15:0] pit_new;
    logic signed [18:0] yaw_signed;
    logic signed [33:0] rnd;

    always_comb begin
        mul_a = r_dx;
        mul_b = $signed({5'd0, r_sens});
        if (r_state == S_MULY) begin
            mul_a = r_dy;
        end else if (r_state == S_PRX) begin
            mul_a = 17'(r_cy);
            mul_b = 17'(r_cp);
        end else if (r_state == S_PRZ) begin
            mul_a = 17'(r_sy);
            mul_b = 17'(r_cp);
        end
        mul_p = mul_a * mul_b;
        if (mul_p > 34'sd92160) begin
            sat_p = FullTurn;
        end else if (mul_p < -34'sd92160) begin
            sat_p = -FullTurn;
        end else begin
            sat_p = mul_p[18:0];
        end
        rnd = (mul_p + 34'sd8192) >>> 14;
        if (rnd > 34'sd16384) begin
            q14_p = OneQ14;
        end else if (rnd < -34'sd16384) begin
            q14_p = -OneQ14;
        end else begin
            q14_p = rnd[15:0];
        end

        yaw_sum = $signed({3'd0, r_yaw}) + 20'(r_sdx);
        if (yaw_sum < 20'sd0) begin
            yaw_wrap = yaw_sum + 20'(FullTurn);
        end else if (yaw_sum >= 20'(FullTurn)) begin
            yaw_wrap = yaw_sum - 20'(FullTurn);
        end else begin
            yaw_wrap = yaw_sum;
        end
        pit_sum = 20'(r_pitch) + 20'(r_sdy);
        if (pit_sum > 20'(PitchLimit)) begin
            pit_new = PitchLimit[15:0];
        end else if (pit_sum < -20'(PitchLimit)) begin
            pit_new = -PitchLimit[15:0];
        end else begin
            pit_new = pit_sum[15:0];
        end

        yaw_signed = $signed({2'd0, r_yaw});
        if (yaw_signed > HalfTurn) begin
            yaw_signed = yaw_signed - FullTurn;
        end
        cs_start = (r_state == S_YAW) || (r_state == S_PIT);
        cs_angle = (r_state == S_PIT) ? 19'(r_pitch) : yaw_signed;
    end

    mlcd_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(cs_start),
        .i_angle(cs_angle),
        .o_done (cs_done),
        .o_cos  (cs_cos),
        .o_sin  (cs_sin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sens   <= SensReset;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_yaw    <= '0;
            r_pitch  <= '0;
            r_first  <= 1'b1;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_sens <= i_look_sensitivity;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cursor_valid) begin
                        if (r_first) begin
                            r_dx <= '0;
                            r_dy <= '0;
                        end else begin
                            r_dx <= 17'(i_cursor_x) - 17'(r_prev_x);
                            r_dy <= 17'(r_prev_y) - 17'(i_cursor_y);
                        end
                        r_first  <= 1'b0;
                        r_prev_x <= i_cursor_x;
                        r_prev_y <= i_cursor_y;
                        r_state  <= S_MULX;
                    end
                end
                S_MULX: begin
                    r_sdx   <= sat_p;
                    r_state <= S_MULY;
                end
                S_MULY: begin
                    r_sdy   <= sat_p;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_yaw   <= yaw_wrap[16:0];
                    r_pitch <= pit_new;
                    r_state <= S_YAW;
                end
                S_YAW: r_state <= S_YAWW;
                S_YAWW: begin
                    if (cs_done) begin
                        r_cy    <= cs_cos;
                        r_sy    <= cs_sin;
                        r_state <= S_PIT;
                    end
                end
                S_PIT: r_state <= S_PITW;
                S_PITW: begin
                    if (cs_done) begin
                        r_cp    <= cs_cos;
                        r_sp    <= cs_sin;
                        r_state <= S_PRX;
                    end
                end
                S_PRX: begin
                    r_ox    <= q14_p;
                    r_state <= S_PRZ;
                end
                S_PRZ: begin
                    r_oz    <= q14_p;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // The result waits here while the output register is full.
                    if (!r_valid || i_dir_ready) begin
                        r_dir_x     <= r_ox;
                        r_dir_y     <= r_sp;
                        r_dir_z     <= r_oz;
                        r_dir_yaw   <= r_yaw;
                        r_dir_pitch <= r_pitch;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if ((r_state == S_OUT) && (!r_valid || i_dir_ready)) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_dir_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_cursor_ready = (r_state == S_IDLE);
    assign o_dir_valid    = r_valid;
    assign o_dir_x        = r_dir_x;
    assign o_dir_y        = r_dir_y;
    assign o_dir_z        = r_dir_z;
    assign o_yaw_angle    = r_dir_yaw;
    assign o_pitch_angle  = r_dir_pitch;

endmodule

FILE: verif/tb.sv
// Testbench for the mouse-look camera direction block: directed table, random items, self-checking.
`timescale 1ns / 1ps

module tb;
    import mlcd_pkg::*;

    localparam int Steps = 16;
    localparam longint CycleLimit = 400000;

    typedef struct {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
        logic [16:0]        yaw;
        logic signed [15:0] pitch;
    } t_look;

    // One directed row: the cursor sample, and optionally an expected result
    // typed in by hand (only where it is plain from the arithmetic).
    typedef struct {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        bit                 typed;
        t_look              want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [11:0]        i_look_sensitivity = '0;
    logic               i_cursor_valid = 1'b0;
    logic               o_cursor_ready;
    logic signed [15:0] i_cursor_x = '0;
    logic signed [15:0] i_cursor_y = '0;
    logic               o_dir_valid;
    logic               i_dir_ready = 1'b0;
    logic signed [15:0] o_dir_x;
    logic signed [15:0] o_dir_y;
    logic signed [15:0] o_dir_z;
    logic [16:0]        o_yaw_angle;
    logic signed [15:0] o_pitch_angle;

    mouse_look_camera_direction #(.CORDIC_STEPS(Steps)) dut (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state, a private copy of what the block holds.
    logic [11:0]        sens_q48;
    logic signed [15:0] last_x;
    logic signed [15:0] last_y;
    longint             yaw_q8;
    longint             pitch_q8;
    bit                 awaiting_seed;

    t_look  pending_looks[$];
    int     mismatch_count = 0;
    longint cycle_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     recv_hold = 1'b0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint atan_q16(int i);
        longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                            57, 29, 14, 7, 4, 2, 1, 0};
        return tab[i];
    endfunction

    // Iterative rotation in degrees; returns cos and sin in Q1.14.
    task automatic rotate_deg(input longint ang, output longint c, output longint s);
        longint x, y, z, nx;
        bit     flip;
        int     n;
        x = 163008219;
        y = 0;
        flip = 1'b0;
        n = Steps > 24 ? 24 : Steps;
        if (ang > 23040) begin
            ang -= 46080;
            flip = 1'b1;
        end else if (ang < -23040) begin
            ang += 46080;
            flip = 1'b1;
        end
        z = ang * 256;
        for (int i = 0; i < n; i++) begin
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                y  = y + floor_shift(x, i);
                z -= atan_q16(i);
            end else begin
                nx = x + floor_shift(y, i);
                y  = y - floor_shift(x, i);
                z += atan_q16(i);
            end
            x = nx;
        end
        x = clip(floor_shift(x + 8192, 14), -16384, 16384);
        y = clip(floor_shift(y + 8192, 14), -16384, 16384);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint q14_product(longint a, longint b);
        return clip(floor_shift(a * b + 8192, 14), -16384, 16384);
    endfunction

    task automatic predict_look(input logic signed [15:0] cx, input logic signed [15:0] cy,
                                output t_look r);
        longint mx, my, yaw_wrapped, cyaw, syaw, cp, sp;
        if (awaiting_seed) begin
            last_x = cx;
            last_y = cy;
            awaiting_seed = 1'b0;
        end
        mx = longint'(cx) - longint'(last_x);
        my = longint'(last_y) - longint'(cy);
        last_x = cx;
        last_y = cy;
        mx = clip(mx * longint'(sens_q48), -92160, 92160);
        my = clip(my * longint'(sens_q48), -92160, 92160);
        yaw_q8 += mx;
        while (yaw_q8 < 0) yaw_q8 += 92160;
        while (yaw_q8 >= 92160) yaw_q8 -= 92160;
        pitch_q8 = clip(pitch_q8 + my, -22784, 22784);
        yaw_wrapped = yaw_q8 > 46080 ? yaw_q8 - 92160 : yaw_q8;
        rotate_deg(yaw_wrapped, cyaw, syaw);
        rotate_deg(pitch_q8, cp, sp);
        r.dx    = 16'(q14_product(cyaw, cp));
        r.dy    = 16'(sp);
        r.dz    = 16'(q14_product(syaw, cp));
        r.yaw   = 17'(yaw_q8);
        r.pitch = 16'(pitch_q8);
    endtask

    // Offer one cursor item, idling first at the current sender rate. Valid
    // stays high after acceptance only when the next item follows at once;
    // the caller drops it at the end of a run of items.
    task automatic send_cursor(input logic signed [15:0] cx, input logic signed [15:0] cy,
                               input bit typed, input t_look want);
        t_look r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_cursor_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cursor_valid <= 1'b1;
        i_cursor_x     <= cx;
        i_cursor_y     <= cy;
        do @(posedge i_clk); while (!o_cursor_ready);
        predict_look(cx, cy, r);
        // A hand-typed row must agree with the predictor too.
        if (typed && r != want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("table row exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                         want.dx, want.dy, want.dz, want.yaw, want.pitch,
                         r.dx, r.dy, r.dz, r.yaw, r.pitch);
        end
        pending_looks.push_back(r);
    endtask

    task automatic drain_results();
        while (pending_looks.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Sensitivity writes happen only with the block idle.
    task automatic write_sens(input logic [11:0] v);
        i_cfg_valid        <= 1'b1;
        i_look_sensitivity <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sens_q48 = v;
    endtask

    task automatic random_burst(input int count);
        logic signed [15:0] cx, cy;
        t_look none;
        none = '{default: '0};
        for (int n = 0; n < count; n++) begin
            // Mostly small moves around the last position; sometimes any value.
            if ($urandom_range(9) < 7) begin
                cx = last_x + 16'($signed($urandom_range(400)) - 200);
                cy = last_y + 16'($signed($urandom_range(400)) - 200);
            end else begin
                cx = 16'($urandom);
                cy = 16'($urandom);
            end
            send_cursor(cx, cy, 1'b0, none);
        end
        i_cursor_valid <= 1'b0;
    endtask

    // The receiver idles at its current rate, or holds off completely while
    // recv_hold is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_dir_ready <= 1'b0;
        end else begin
            i_dir_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Each accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_look e;
        if (i_rst_n && o_dir_valid && i_dir_ready) begin
            if (pending_looks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected direction item");
            end else begin
                e = pending_looks.pop_front();
                if (o_dir_x !== e.dx || o_dir_y !== e.dy || o_dir_z !== e.dz ||
                    o_yaw_angle !== e.yaw || o_pitch_angle !== e.pitch) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                                 e.dx, e.dy, e.dz, e.yaw, e.pitch, o_dir_x, o_dir_y,
                                 o_dir_z, o_yaw_angle, o_pitch_angle);
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("tb: errors");
            $finish;
        end
    end

    // A long receiver hold-off, counted in its own process, so the block
    // fills and stalls its input while items keep being offered.
    task automatic long_hold();
        recv_hold = 1'b1;
        repeat (300) @(posedge i_clk);
        recv_hold = 1'b0;
    endtask

    t_row table_rows[$];

    initial begin
        t_look z;
        z = '{default: '0};
        // The first sample only seeds the position: zero yaw and pitch, looking along x.
        table_rows.push_back('{16'sd100, -16'sd50, 1'b1, '{16'sd16384, 0, 0, 0, 0}});
        table_rows.push_back('{16'sd100, -16'sd50, 1'b1, '{16'sd16384, 0, 0, 0, 0}});
        // Extremes of both fields: scaled deltas saturate, pitch clamps.
        table_rows.push_back('{16'sh7fff, 16'sh8000, 1'b0, z});
        table_rows.push_back('{16'sh8000, 16'sh7fff, 1'b0, z});
        table_rows.push_back('{16'sh7fff, 16'sh7fff, 1'b0, z});
        table_rows.push_back('{16'sh8000, 16'sh8000, 1'b0, z});
        table_rows.push_back('{16'sd0, 16'sd0, 1'b0, z});
        // Small steps that walk yaw past the half and full turn.
        for (int i = 1; i <= 8; i++)
            table_rows.push_back('{16'(i * 90), 16'(-i * 20), 1'b0, z});
        table_rows.push_back('{-16'sd1, 16'sd1, 1'b0, z});
        table_rows.push_back('{16'sh5555, 16'shaaaa, 1'b0, z});

        sens_q48 = SensReset;
        last_x = '0;
        last_y = '0;
        yaw_q8 = 0;
        pitch_q8 = 0;
        awaiting_seed = 1'b1;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i])
            send_cursor(table_rows[i].cx, table_rows[i].cy, table_rows[i].typed,
                        table_rows[i].want);
        i_cursor_valid <= 1'b0;
        drain_results();

        // Several sensitivity settings, extremes included, with the three idling phases.
        write_sens(12'd4095);
        send_idle_pct = 24;
        recv_idle_pct = 75;
        random_burst(200);
        drain_results();
        write_sens(12'd0);
        random_burst(50);
        drain_results();
        write_sens(12'd1);
        send_idle_pct = 75;
        recv_idle_pct = 24;
        fork
            long_hold();
            random_burst(250);
        join
        drain_results();
        write_sens(12'd128);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_burst(250);
        drain_results();
        write_sens(12'(32 + $urandom_range(600)));
        random_burst(250);
        drain_results();

        if (mismatch_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/mlcd_pkg.sv
rtl/core/mlcd_cordic.sv
rtl/core/mouse_look_camera_direction.sv
verif/tb.sv
